// ===== hw/rtl/ttcws_pkg.sv =====
// Shared types and constants for the text table column width scanner.
// Depends on nothing; every other file of the block but ttcws_ram imports it.
package ttcws_pkg;

   // Table geometry and width arithmetic
   localparam int MAX_COLUMNS = 256;
   localparam int WIDTH_BITS  = 16;
   localparam int COL_BITS    = $clog2(MAX_COLUMNS + 2);
   localparam int ADDR_BITS   = $clog2(MAX_COLUMNS);

   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};
   localparam logic [COL_BITS-1:0]   COL_LIMIT = COL_BITS'(MAX_COLUMNS);
   localparam logic [COL_BITS-1:0]   COL_OVER  = COL_BITS'(MAX_COLUMNS + 1);

   // Characters with a meaning of their own
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Beat packing
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 48;

   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_END   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_FINISH = 1'b1
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;   // latch the beat, issue the table read
      logic commit;   // update state, write table, load result
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free; // result register empty or being drained
   } dpath_stat_type;

endpackage

// ===== hw/rtl/text_table_column_width_scanner.sv =====
// Top level of the text table column width scanner.
// Depends on ttcws_pkg, ttcws_ctrl, ttcws_dpath and ttcws_ram.
//
// Usage:
//   The request channel carries one operation per beat: a text byte, end of
//   input, a column read or a table clear (operation in req_tuser). Every
//   request beat yields exactly one response beat, in order, carrying the
//   read width (zero unless reading), the greatest committed column count,
//   the widest column so far, the empty-input flag and the sticky
//   too-many-columns flag.
//   Handling of a beat: a beat is accepted and the column table read is
//   issued; in the commit state the column is written back and the response
//   register loaded. No new beat is accepted until the previous one has
//   committed. The registered read of the column table sets this two-step
//   handling.
//   The response register parts the channels: a new beat is accepted while
//   an earlier response waits. If the receiver stalls, the next beat holds
//   in its commit cycle until the response register is free.
//   Reset (synchronous, active high) empties the table at once through its
//   per-column valid bits; no clearing pass is needed and req_tready rises
//   in the first cycle after reset.
module text_table_column_width_scanner (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] data_byte, [16:8] column_select, rest zero
   input  logic [ttcws_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [1:0]                            req_tuser,  // [1:0] operation
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [15:0] column_width, [24:16] column_count, [40:25] widest_column,
   // [41] empty_input, [42] too_many_columns, rest zero
   output logic [ttcws_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import ttcws_pkg::*;

   ctrl_cmd_type          cmd;
   dpath_stat_type        stat;
   logic [WIDTH_BITS-1:0] rsp_width, rsp_widest;
   logic [COL_BITS-1:0]   rsp_count;
   logic                  rsp_empty, rsp_overflow;

   ttcws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ttcws_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_op       (req_tuser),
      .req_byte     (req_tdata[7:0]),
      .req_sel      (req_tdata[16:8]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_width    (rsp_width),
      .rsp_count    (rsp_count),
      .rsp_widest   (rsp_widest),
      .rsp_empty    (rsp_empty),
      .rsp_overflow (rsp_overflow)
   );

   // Pack the response beat
   assign rsp_tdata = {5'd0, rsp_overflow, rsp_empty, rsp_widest, rsp_count, rsp_width};

endmodule

// ===== hw/rtl/ttcws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttcws_ram #(
   parameter int DATA_BITS = 16,
   parameter int DEPTH     = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0]       wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_BITS-1:0]       rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ttcws_ctrl.sv =====
// Controller of the column width scanner: accept one beat, then commit it.
// Depends on ttcws_pkg.
module ttcws_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  ttcws_pkg::dpath_stat_type stat,
   output ttcws_pkg::ctrl_cmd_type   cmd
);
   import ttcws_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for room in the result register
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ttcws_dpath.sv =====
// Datapath of the column width scanner: row state, column table with valid
// bits, read-modify-write of one column and the result register.
// Depends on ttcws_pkg and ttcws_ram.
module ttcws_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ttcws_pkg::ctrl_cmd_type              cmd,
   output ttcws_pkg::dpath_stat_type            stat,
   input  logic [1:0]                           req_op,
   input  logic [7:0]                           req_byte,
   input  logic [ttcws_pkg::COL_BITS-1:0]       req_sel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ttcws_pkg::WIDTH_BITS-1:0]     rsp_width,
   output logic [ttcws_pkg::COL_BITS-1:0]       rsp_count,
   output logic [ttcws_pkg::WIDTH_BITS-1:0]     rsp_widest,
   output logic                                 rsp_empty,
   output logic                                 rsp_overflow
);
   import ttcws_pkg::*;

   // Latched beat
   op_type                op_ff;
   logic [7:0]            byte_ff;
   logic [COL_BITS-1:0]   sel_ff;

   // Scanner state
   logic [COL_BITS-1:0]   cur_col_ff,  cur_col_in;
   logic [WIDTH_BITS-1:0] tok_w_ff,    tok_w_in;
   logic [COL_BITS-1:0]   max_cnt_ff,  max_cnt_in;
   logic [WIDTH_BITS-1:0] widest_ff,   widest_in;
   logic                  any_seen_ff, any_seen_in;
   logic                  ovf_ff,      ovf_in;
   logic [MAX_COLUMNS-1:0] valid_ff;
   logic                  ent_valid_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic [WIDTH_BITS-1:0] rsp_width_ff,  width_out;
   logic [COL_BITS-1:0]   rsp_count_ff;
   logic [WIDTH_BITS-1:0] rsp_widest_ff;
   logic                  rsp_empty_ff,  empty_out;
   logic                  rsp_ovf_ff;

   // Table access
   logic [ADDR_BITS-1:0]  rd_addr, slot;
   logic [WIDTH_BITS-1:0] ram_q, entry, merged;
   logic                  col_in_range, sel_in_range;
   logic                  do_store, do_clear, wr_en;
   logic [COL_BITS-1:0]   sel_dec, col_dec, row_cols;

   assign sel_dec = req_sel - COL_BITS'(1);
   assign col_dec = cur_col_ff - COL_BITS'(1);
   assign rd_addr = (op_type'(req_op) == OP_READ) ? sel_dec[ADDR_BITS-1:0]
                                                  : col_dec[ADDR_BITS-1:0];
   assign slot    = col_dec[ADDR_BITS-1:0];

   ttcws_ram #(
      .DATA_BITS (WIDTH_BITS),
      .DEPTH     (MAX_COLUMNS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (merged),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Latch the beat and the valid bit of the entry being read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= op_type'(req_op);
         byte_ff      <= req_byte;
         sel_ff       <= req_sel;
         ent_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Merge the current token into its column
   assign entry        = ent_valid_ff ? ram_q : '0;
   assign merged       = (tok_w_ff > entry) ? tok_w_ff : entry;
   assign col_in_range = (cur_col_ff != '0) && (cur_col_ff <= COL_LIMIT);
   assign sel_in_range = (sel_ff != '0) && (sel_ff <= COL_LIMIT);
   assign row_cols     = (cur_col_ff > COL_LIMIT) ? COL_LIMIT : cur_col_ff;

   // Next state for the committed beat
   always_comb begin
      cur_col_in  = cur_col_ff;
      tok_w_in    = tok_w_ff;
      max_cnt_in  = max_cnt_ff;
      widest_in   = widest_ff;
      any_seen_in = any_seen_ff;
      ovf_in      = ovf_ff;
      do_store    = 1'b0;
      do_clear    = 1'b0;
      width_out   = '0;
      empty_out   = 1'b0;
      case (op_ff)
         OP_DATA: begin
            any_seen_in = 1'b1;
            if (byte_ff == CHAR_NEWLINE) begin
               do_store   = 1'b1;
               max_cnt_in = (row_cols > max_cnt_ff) ? row_cols : max_cnt_ff;
               cur_col_in = '0;
               tok_w_in   = '0;
            end else if (byte_ff <= CHAR_SPACE) begin
               if (tok_w_ff != '0) begin
                  do_store = 1'b1;
                  tok_w_in = '0;
               end
            end else begin
               // first character opens a new column
               if (tok_w_ff == '0) begin
                  if (cur_col_ff < COL_LIMIT) begin
                     cur_col_in = cur_col_ff + COL_BITS'(1);
                  end else begin
                     cur_col_in = COL_OVER;
                     ovf_in     = 1'b1;
                  end
               end
               if (tok_w_ff != WIDTH_MAX) begin
                  tok_w_in = tok_w_ff + WIDTH_BITS'(1);
               end
            end
         end
         OP_END: begin
            empty_out  = !any_seen_ff;
            do_store   = 1'b1;
            max_cnt_in = (row_cols > max_cnt_ff) ? row_cols : max_cnt_ff;
            cur_col_in = '0;
            tok_w_in   = '0;
         end
         OP_READ: begin
            if (sel_in_range) begin
               width_out = entry;
            end
         end
         OP_CLEAR: begin
            do_clear    = 1'b1;
            cur_col_in  = '0;
            tok_w_in    = '0;
            max_cnt_in  = '0;
            widest_in   = '0;
            any_seen_in = 1'b0;
            ovf_in      = 1'b0;
         end
         default: begin
            do_clear = 1'b0;
         end
      endcase
      if (do_store && col_in_range && (merged > widest_ff)) begin
         widest_in = merged;
      end
   end

   assign wr_en = cmd.commit && do_store && col_in_range;

   // Scanner state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff  <= '0;
         tok_w_ff    <= '0;
         max_cnt_ff  <= '0;
         widest_ff   <= '0;
         any_seen_ff <= 1'b0;
         ovf_ff      <= 1'b0;
      end else if (cmd.commit) begin
         cur_col_ff  <= cur_col_in;
         tok_w_ff    <= tok_w_in;
         max_cnt_ff  <= max_cnt_in;
         widest_ff   <= widest_in;
         any_seen_ff <= any_seen_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Valid bits: drop all on reset or clear, mark each written column
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && do_clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[slot] <= 1'b1;
      end
   end

   // Result register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_width_ff  <= width_out;
         rsp_count_ff  <= max_cnt_in;
         rsp_widest_ff <= widest_in;
         rsp_empty_ff  <= empty_out;
         rsp_ovf_ff    <= ovf_in;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_width     = rsp_width_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_widest    = rsp_widest_ff;
   assign rsp_empty     = rsp_empty_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

// ===== hw/rtl/ttcws_checker.sv =====
// Port-level checks for the text table column width scanner, bound to the top.
// Depends on ttcws_pkg.
module ttcws_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [1:0]                          req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ttcws_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import ttcws_pkg::*;

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // One beat in flight: no acceptance in the cycle after an acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous beat still committing");

   // With the response side free at acceptance, the beat commits without a stall and a response follows
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (!rsp_tvalid || rsp_tready) |=> ##1 rsp_tvalid)
      else $error("response missing two cycles after acceptance");

   // A clear returns every response field to zero
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_CLEAR) &&
      (!rsp_tvalid || rsp_tready) |=> ##1 (rsp_tdata == '0))
      else $error("clear left response fields non-zero");

   // Column count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:16] <= COL_LIMIT))
      else $error("column count beyond table size");

endmodule

bind text_table_column_width_scanner ttcws_checker u_ttcws_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
